// ===== sv/nocd_pkg.sv =====
// Package for the nearest occupied cell distance unit.
// Holds register indexes, widths and the front-to-back queue entry type.
// Depends on nothing.
package nocd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAP       = 3'd7;

  localparam logic [31:0] AXIS_SAT  = 32'h8000_0000;
  localparam logic [30:0] CAP_RESET = 31'd65536000;

  typedef struct packed {
    logic                  occupied;
    logic                  last;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
  } cell_t;

  typedef struct packed {
    logic [63:0] best;
    logic        found;
  } frame_t;

endpackage

// ===== sv/nocd_front.sv =====
// Front part: accepts cells, classifies occupancy, keeps row and column counters.
// Depends on nocd_pkg.
module nocd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [7:0]      occupancy,
  input  logic                   last_cell,
  input  logic [15:0]            map_width,
  input  logic [6:0]             threshold,
  output logic                   q_valid,
  input  logic                   q_ready,
  output nocd_pkg::cell_t        q_data
);
  import nocd_pkg::*;

  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [16:0]           next_col;
  logic                  fire;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign fire     = in_valid && q_ready;

  assign q_data.occupied = (occupancy > $signed({1'b0, threshold}));
  assign q_data.last     = last_cell;
  assign q_data.row      = row_r;
  assign q_data.col      = col_r;

  assign next_col = {1'b0, col_r} + 17'd1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (fire) begin
      if (last_cell) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (next_col >= {1'b0, map_width}) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = next_col[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== sv/nocd_queue.sv =====
// Two-entry queue between the front and the back part.
// Depends on nocd_pkg.
module nocd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  nocd_pkg::cell_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output nocd_pkg::cell_t rd_data
);
  import nocd_pkg::*;

  cell_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== sv/nocd_back.sv =====
// Back part: position products, squared distance, running minimum and square root.
// Depends on nocd_pkg.
module nocd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  nocd_pkg::cell_t        q_data,
  input  logic [31:0]            cell_size,
  input  logic [31:0]            origin_x,
  input  logic [31:0]            origin_y,
  input  logic [31:0]            robot_x,
  input  logic [31:0]            robot_y,
  input  logic [30:0]            distance_cap,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [30:0]            min_distance,
  output logic                   obstacle_found
);
  import nocd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  cell_t       cell_r;
  logic [47:0] px_r, py_r;
  logic [31:0] dx_r, dy_r;
  logic [63:0] sq_r;
  frame_t      fr_r, fr_nxt;
  logic [63:0] rem_r, root_r, bit_r;
  logic [30:0] res_r;
  logic        resf_r;

  logic signed [49:0] gx, gy;
  logic [49:0]        ax, ay;
  logic [64:0]        trial;
  logic [63:0]        sq_w, sqy_w;
  logic               upd;
  logic [63:0]        best_w;
  logic               found_w;

  assign q_ready = (st_r == ST_IDLE);
  assign out_valid      = (st_r == ST_OUT);
  assign min_distance   = res_r;
  assign obstacle_found = resf_r;

  assign gx = $signed({2'b00, px_r}) + 50'(signed'(origin_x)) - 50'(signed'(robot_x));
  assign gy = $signed({2'b00, py_r}) + 50'(signed'(origin_y)) - 50'(signed'(robot_y));
  assign ax = gx[49] ? 50'(-gx) : 50'(gx);
  assign ay = gy[49] ? 50'(-gy) : 50'(gy);
  assign trial = {1'b0, root_r} + {1'b0, bit_r};

  assign sq_w  = 64'(dx_r) * 64'(dx_r);
  assign sqy_w = 64'(dy_r) * 64'(dy_r);

  assign upd     = cell_r.occupied && (sq_r < fr_r.best);
  assign best_w  = upd ? sq_r : fr_r.best;
  assign found_w = upd | fr_r.found;

  always_comb begin
    st_nxt = st_r;
    fr_nxt = fr_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_SQ;
      ST_SQ:   st_nxt = ST_ACC;
      ST_ACC:  st_nxt = ST_CMP;
      ST_CMP: begin
        if (cell_r.last) begin
          fr_nxt.best  = 64'(distance_cap) * 64'(distance_cap);
          fr_nxt.found = 1'b0;
          st_nxt       = ST_ROOT;
        end else begin
          fr_nxt.best  = best_w;
          fr_nxt.found = found_w;
          st_nxt       = ST_IDLE;
        end
      end
      ST_ROOT: if (bit_r == 64'd0) st_nxt = ST_OUT;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: if (q_valid) cell_r <= q_data;
      ST_MUL: begin
        px_r <= 48'(cell_r.row) * 48'(cell_size);
        py_r <= 48'(cell_r.col) * 48'(cell_size);
      end
      ST_SQ: begin
        dx_r <= (ax > 50'(AXIS_SAT)) ? AXIS_SAT : ax[31:0];
        dy_r <= (ay > 50'(AXIS_SAT)) ? AXIS_SAT : ay[31:0];
      end
      ST_ACC: sq_r <= sq_w + sqy_w;
      ST_CMP: begin
        rem_r  <= best_w;
        resf_r <= found_w;
        root_r <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
      end
      ST_ROOT: begin
        if (bit_r == 64'd0) begin
          res_r  <= root_r[30:0];
        end else if ({1'b0, rem_r} >= trial) begin
          rem_r  <= rem_r - trial[63:0];
          root_r <= (root_r >> 1) + bit_r;
          bit_r  <= bit_r >> 2;
        end else begin
          root_r <= root_r >> 1;
          bit_r  <= bit_r >> 2;
        end
      end
      default: ;
    endcase
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      fr_r.best     <= 64'(CAP_RESET) * 64'(CAP_RESET);
      fr_r.found    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fr_r <= fr_nxt;
    end
  end

endmodule

// ===== sv/nearest_occupied_cell_distance_unit.sv =====
// Top level of the nearest occupied cell distance unit.
// Holds the register file; instantiates nocd_front, nocd_queue and nocd_back.
//
//   channel | direction | payload
//   in_     | input     | in_occupancy, in_last_cell
//   out_    | output    | out_min_distance, out_obstacle_found
//   cfg_    | input     | cfg_index, cfg_data
//
// Each cell goes through five steps in the back part: the transfer from the queue,
// the index products, the offset and saturation step, the squares and their
// sum, and the compare. A last cell then goes through the bit-pair square
// root and holds the result until its transfer. The front counts cells
// and a two-entry queue decouples it from the back. Reset loads all registers
// to their defaults, clears counters and resets the running minimum.
module nearest_occupied_cell_distance_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [7:0]  in_occupancy,
  input  logic               in_last_cell,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        out_min_distance,
  output logic               out_obstacle_found,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [nocd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);
  import nocd_pkg::*;

  logic [15:0] map_width_r;
  logic [31:0] cell_size_r, origin_x_r, origin_y_r, robot_x_r, robot_y_r;
  logic [6:0]  threshold_r;
  logic [30:0] cap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= 16'd1024;
      cell_size_r <= 32'd3277;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      robot_x_r   <= '0;
      robot_y_r   <= '0;
      threshold_r <= 7'd90;
      cap_r       <= CAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_WIDTH: map_width_r <= cfg_data[15:0];
        REG_CELL_SIZE: cell_size_r <= cfg_data;
        REG_ORIGIN_X:  origin_x_r  <= cfg_data;
        REG_ORIGIN_Y:  origin_y_r  <= cfg_data;
        REG_ROBOT_X:   robot_x_r   <= cfg_data;
        REG_ROBOT_Y:   robot_y_r   <= cfg_data;
        REG_THRESHOLD: threshold_r <= cfg_data[6:0];
        REG_CAP:       cap_r       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  cell_t fq_data, qb_data;

  nocd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .occupancy(in_occupancy), .last_cell(in_last_cell),
    .map_width(map_width_r), .threshold(threshold_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  nocd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  nocd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .cell_size(cell_size_r), .origin_x(origin_x_r), .origin_y(origin_y_r),
    .robot_x(robot_x_r), .robot_y(robot_y_r), .distance_cap(cap_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .min_distance(out_min_distance), .obstacle_found(out_obstacle_found)
  );

endmodule
